>>> hw/rtl/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg
// Types, codes and reset values shared by the axis homing sequencer.
// ----------------------------------------------------------------------------
package ahs_pkg;

	localparam int SPEED_W = 13;
	localparam int PULSE_W = 24;
	localparam int POS_W   = 24;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_COUNT_DIRECTION      = 3'd0;
	localparam logic [IDX_W-1:0] REG_HOME_TOWARD_NEGATIVE = 3'd1;
	localparam logic [IDX_W-1:0] REG_SENSOR_ACTIVE_HIGH   = 3'd2;
	localparam logic [IDX_W-1:0] REG_FAST_SPEED           = 3'd3;
	localparam logic [IDX_W-1:0] REG_SLOW_SPEED           = 3'd4;
	localparam logic [IDX_W-1:0] REG_WORK_SPEED           = 3'd5;
	localparam logic [IDX_W-1:0] REG_BACKOFF_PULSES       = 3'd6;

	// reset values
	localparam logic               RST_COUNT_DIRECTION      = 1'b0;
	localparam logic               RST_HOME_TOWARD_NEGATIVE = 1'b0;
	localparam logic               RST_SENSOR_ACTIVE_HIGH   = 1'b1;
	localparam logic [SPEED_W-1:0] RST_FAST_SPEED           = 13'd50;
	localparam logic [SPEED_W-1:0] RST_SLOW_SPEED           = 13'd5;
	localparam logic [SPEED_W-1:0] RST_WORK_SPEED           = 13'd1000;
	localparam logic [PULSE_W-1:0] RST_BACKOFF_PULSES       = 24'd25;

	// stop mode codes
	localparam logic [1:0] STOP_NONE   = 2'd0;
	localparam logic [1:0] STOP_CODE8  = 2'd1;
	localparam logic [1:0] STOP_CODE12 = 2'd2;

	// move command codes
	localparam logic [2:0] MOVE_NONE = 3'd0;
	localparam logic [2:0] JOG_FWD   = 3'd1;
	localparam logic [2:0] JOG_REV   = 3'd2;
	localparam logic [2:0] PULSE_FWD = 3'd3;
	localparam logic [2:0] PULSE_REV = 3'd4;

	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

	typedef enum logic [7:0] {
		PH_STOP     = 8'b0000_0001,
		PH_SEARCH   = 8'b0000_0010,
		PH_LEAVE    = 8'b0000_0100,
		PH_BACKOFF  = 8'b0000_1000,
		PH_APPROACH = 8'b0001_0000,
		PH_CHECK    = 8'b0010_0000,
		PH_LATCH    = 8'b0100_0000,
		PH_DONE     = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic               count_direction;
		logic               home_toward_negative;
		logic               sensor_active_high;
		logic [SPEED_W-1:0] fast_speed;
		logic [SPEED_W-1:0] slow_speed;
		logic [SPEED_W-1:0] work_speed;
		logic [PULSE_W-1:0] backoff_pulses;
	} cfg_t;

	typedef struct packed {
		logic                    action;
		logic                    busy_req;
		logic                    home_input;
		logic                    stopped_by_home;
		logic                    stop_flag_a;
		logic                    stop_flag_b;
		logic signed [POS_W-1:0] position_raw;
	} in_item_t;

	typedef struct packed {
		logic                    issue_stop;
		logic                    speed_write;
		logic [SPEED_W-1:0]      speed_value;
		logic                    stop_mode_write;
		logic [1:0]              stop_mode;
		logic [2:0]              move_cmd;
		logic [PULSE_W-1:0]      move_pulses;
		logic [3:0]              phase;
		logic                    done_res;
		logic signed [POS_W-1:0] home_position;
	} out_item_t;

	function automatic logic [3:0] phase_num(input phase_t ph);
		logic [3:0] n;
		unique case (ph)
			PH_STOP:     n = 4'd1;
			PH_SEARCH:   n = 4'd2;
			PH_LEAVE:    n = 4'd3;
			PH_BACKOFF:  n = 4'd4;
			PH_APPROACH: n = 4'd5;
			PH_CHECK:    n = 4'd6;
			PH_LATCH:    n = 4'd7;
			PH_DONE:     n = 4'd8;
			default:     n = 4'd0;
		endcase
		return n;
	endfunction

	// zero speed is sent as one
	function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
		return (s == '0) ? SPEED_W'(1) : s;
	endfunction

endpackage

>>> hw/rtl/axis_homing_sequencer.sv
// ----------------------------------------------------------------------------
// axis_homing_sequencer
// Homing sequence for one motion axis: one status poll in, one command out.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake           payload
//  in_*         in   in_valid/in_ready   ahs_pkg::in_item_t  (status poll)
//  out_*        out  out_valid/out_ready ahs_pkg::out_item_t (command word)
//  cfg_*        in   cfg_we              cfg_index, cfg_data (write only)
//
// For each poll the phase register and the latched home position update at
// the accept edge, and the command word lands in the output register, visible
// the next cycle. A new poll is taken every cycle
// as long as the output register is empty or being drained in that cycle;
// a stalled output holds only its own word and back-pressures the input.
// Reset (arst_n low) returns phase 1, home position zero, default settings
// and an empty output register.
// ----------------------------------------------------------------------------
module axis_homing_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	// status poll requests
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ahs_pkg::in_item_t               in_data,
	// command word requests
	output logic                            out_valid,
	input  logic                            out_ready,
	output ahs_pkg::out_item_t              out_data,
	// settings
	input  logic                            cfg_we,
	input  logic [ahs_pkg::IDX_W-1:0]       cfg_index,
	input  logic [ahs_pkg::CFG_W-1:0]       cfg_data
);

	ahs_pkg::cfg_t                     cfg_q;
	ahs_pkg::phase_t                   phase_q;
	logic signed [ahs_pkg::POS_W-1:0]  home_q;
	ahs_pkg::phase_t                   phase_nxt;
	logic signed [ahs_pkg::POS_W-1:0]  home_nxt;
	ahs_pkg::out_item_t                res;
	ahs_pkg::out_item_t                out_q;
	logic                              out_valid_q;
	logic                              accept;

	// output register empty or draining this cycle
	assign in_ready  = ~out_valid_q | out_ready;
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// settings registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_direction      <= ahs_pkg::RST_COUNT_DIRECTION;
			cfg_q.home_toward_negative <= ahs_pkg::RST_HOME_TOWARD_NEGATIVE;
			cfg_q.sensor_active_high   <= ahs_pkg::RST_SENSOR_ACTIVE_HIGH;
			cfg_q.fast_speed           <= ahs_pkg::RST_FAST_SPEED;
			cfg_q.slow_speed           <= ahs_pkg::RST_SLOW_SPEED;
			cfg_q.work_speed           <= ahs_pkg::RST_WORK_SPEED;
			cfg_q.backoff_pulses       <= ahs_pkg::RST_BACKOFF_PULSES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ahs_pkg::REG_COUNT_DIRECTION:      cfg_q.count_direction      <= cfg_data[0];
				ahs_pkg::REG_HOME_TOWARD_NEGATIVE: cfg_q.home_toward_negative <= cfg_data[0];
				ahs_pkg::REG_SENSOR_ACTIVE_HIGH:   cfg_q.sensor_active_high   <= cfg_data[0];
				ahs_pkg::REG_FAST_SPEED: begin
					cfg_q.fast_speed <= cfg_data[ahs_pkg::SPEED_W-1:0];
				end
				ahs_pkg::REG_SLOW_SPEED: begin
					cfg_q.slow_speed <= cfg_data[ahs_pkg::SPEED_W-1:0];
				end
				ahs_pkg::REG_WORK_SPEED: begin
					cfg_q.work_speed <= cfg_data[ahs_pkg::SPEED_W-1:0];
				end
				ahs_pkg::REG_BACKOFF_PULSES: begin
					cfg_q.backoff_pulses <= cfg_data[ahs_pkg::PULSE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// phase decode and command build for the incoming poll
	ahs_step u_step (
		.cfg       (cfg_q),
		.phase_cur (phase_q),
		.home_cur  (home_q),
		.item      (in_data),
		.phase_nxt (phase_nxt),
		.home_nxt  (home_nxt),
		.res       (res)
	);

	// sequence state advances only on an accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ahs_pkg::PH_STOP;
			home_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			home_q  <= home_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

endmodule

>>> hw/rtl/ahs_step.sv
// ----------------------------------------------------------------------------
// ahs_step
// Next phase, latched position and command word for one status poll.
// ----------------------------------------------------------------------------
module ahs_step (
	input  ahs_pkg::cfg_t                          cfg,
	input  ahs_pkg::phase_t                        phase_cur,
	input  logic signed [ahs_pkg::POS_W-1:0]       home_cur,
	input  ahs_pkg::in_item_t                      item,
	output ahs_pkg::phase_t                        phase_nxt,
	output logic signed [ahs_pkg::POS_W-1:0]       home_nxt,
	output ahs_pkg::out_item_t                     res
);

	logic       home_flag;
	logic       at_home;
	logic [1:0] mode_seek;
	logic [1:0] mode_leave;
	logic [2:0] jog_pos;
	logic [2:0] jog_neg;
	logic [2:0] jog_toward;
	logic [2:0] jog_away;
	logic       lim_n;
	logic       lim_p;
	logic signed [ahs_pkg::POS_W-1:0] pos_corr;

	assign home_flag  = cfg.sensor_active_high ? item.home_input : ~item.home_input;
	assign at_home    = item.stopped_by_home | home_flag;
	assign mode_seek  = cfg.sensor_active_high ? ahs_pkg::STOP_CODE12 : ahs_pkg::STOP_CODE8;
	assign mode_leave = cfg.sensor_active_high ? ahs_pkg::STOP_CODE8 : ahs_pkg::STOP_CODE12;
	assign jog_pos    = cfg.count_direction ? ahs_pkg::JOG_FWD : ahs_pkg::JOG_REV;
	assign jog_neg    = cfg.count_direction ? ahs_pkg::JOG_REV : ahs_pkg::JOG_FWD;
	assign jog_toward = cfg.home_toward_negative ? jog_neg : jog_pos;
	assign jog_away   = cfg.home_toward_negative ? jog_pos : jog_neg;
	assign lim_n      = cfg.count_direction ? item.stop_flag_b : item.stop_flag_a;
	assign lim_p      = cfg.count_direction ? item.stop_flag_a : item.stop_flag_b;

	// mirrored counting negates, saturating the most negative value
	always_comb begin
		if (cfg.count_direction) begin
			pos_corr = item.position_raw;
		end else if (item.position_raw == ahs_pkg::POS_MIN) begin
			pos_corr = ahs_pkg::POS_MAX;
		end else begin
			pos_corr = -item.position_raw;
		end
	end

	always_comb begin
		phase_nxt = phase_cur;
		home_nxt  = home_cur;
		res       = '0;
		if (!item.action) begin
			phase_nxt = ahs_pkg::PH_STOP;
		end else begin
			unique case (phase_cur)
				ahs_pkg::PH_STOP: begin
					res.issue_stop = 1'b1;
					if (!item.busy_req) begin
						res.speed_write     = 1'b1;
						res.speed_value     = ahs_pkg::clamp_speed(cfg.fast_speed);
						res.stop_mode_write = 1'b1;
						res.stop_mode       = mode_seek;
						if (!home_flag) begin
							res.move_cmd = jog_toward;
						end
						phase_nxt = ahs_pkg::PH_SEARCH;
					end
				end
				ahs_pkg::PH_SEARCH: begin
					if (!item.busy_req) begin
						priority if (at_home) begin
							phase_nxt = ahs_pkg::PH_LEAVE;
						end else if (lim_n) begin
							res.move_cmd = jog_pos;
						end else if (lim_p) begin
							res.move_cmd = jog_neg;
						end else begin
							res.move_cmd = jog_toward;
						end
					end
				end
				ahs_pkg::PH_LEAVE: begin
					if (!item.busy_req) begin
						res.stop_mode_write = 1'b1;
						res.stop_mode       = mode_leave;
						res.move_cmd        = jog_away;
						phase_nxt           = ahs_pkg::PH_BACKOFF;
					end
				end
				ahs_pkg::PH_BACKOFF: begin
					if (!item.busy_req) begin
						res.speed_write = 1'b1;
						res.speed_value = ahs_pkg::clamp_speed(cfg.slow_speed);
						res.move_cmd    = (cfg.count_direction == cfg.home_toward_negative) ?
						                  ahs_pkg::PULSE_FWD : ahs_pkg::PULSE_REV;
						res.move_pulses = cfg.backoff_pulses;
						phase_nxt       = ahs_pkg::PH_APPROACH;
					end
				end
				ahs_pkg::PH_APPROACH: begin
					if (!item.busy_req) begin
						res.speed_write     = 1'b1;
						res.speed_value     = ahs_pkg::clamp_speed(cfg.slow_speed);
						res.stop_mode_write = 1'b1;
						res.stop_mode       = mode_seek;
						res.move_cmd        = jog_toward;
						phase_nxt           = ahs_pkg::PH_CHECK;
					end
				end
				ahs_pkg::PH_CHECK: begin
					if (!item.busy_req) begin
						phase_nxt = at_home ? ahs_pkg::PH_LATCH : ahs_pkg::PH_STOP;
					end
				end
				ahs_pkg::PH_LATCH: begin
					home_nxt            = pos_corr;
					res.stop_mode_write = 1'b1;
					res.stop_mode       = ahs_pkg::STOP_NONE;
					res.speed_write     = 1'b1;
					res.speed_value     = ahs_pkg::clamp_speed(cfg.work_speed);
					phase_nxt           = ahs_pkg::PH_DONE;
				end
				default: begin
					// done, or an illegal code: hold, no command
				end
			endcase
		end
		res.phase         = ahs_pkg::phase_num(phase_nxt);
		res.done_res      = (phase_nxt == ahs_pkg::PH_DONE);
		res.home_position = home_nxt;
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for axis_homing_sequencer. A table of directed status
// polls walks the homing phases with one missed home, then random polls
// run under eight settings (defaults, all-minimum, all-maximum, mixed).
// Each command word is checked by field against a typed row or cycle-free model.
// ----------------------------------------------------------------------------
module tb;

	// phase numbers as they appear in the command word
	localparam logic [3:0] PHASE_STOP     = 4'd1;
	localparam logic [3:0] PHASE_SEARCH   = 4'd2;
	localparam logic [3:0] PHASE_LEAVE    = 4'd3;
	localparam logic [3:0] PHASE_BACKOFF  = 4'd4;
	localparam logic [3:0] PHASE_APPROACH = 4'd5;
	localparam logic [3:0] PHASE_CHECK    = 4'd6;
	localparam logic [3:0] PHASE_LATCH    = 4'd7;
	localparam logic [3:0] PHASE_DONE     = 4'd8;

	// index past the register list, must be ignored
	localparam logic [ahs_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int STALL_LIMIT   = 4000;
	localparam int RAND_BLOCKS   = 8;
	localparam int POLLS_PER_SET = 219;

	typedef struct {
		ahs_pkg::in_item_t  req;
		bit                 typed;
		ahs_pkg::out_item_t cmd;
	} poll_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ahs_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ahs_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [ahs_pkg::IDX_W-1:0] cfg_index = '0;
	logic [ahs_pkg::CFG_W-1:0] cfg_data = '0;

	// hand-typed expectation riding along with the current request
	bit typed_q = 1'b0;
	ahs_pkg::out_item_t typed_cmd = '0;

	// model state
	ahs_pkg::cfg_t set_q = '{ahs_pkg::RST_COUNT_DIRECTION, ahs_pkg::RST_HOME_TOWARD_NEGATIVE,
		ahs_pkg::RST_SENSOR_ACTIVE_HIGH, ahs_pkg::RST_FAST_SPEED, ahs_pkg::RST_SLOW_SPEED,
		ahs_pkg::RST_WORK_SPEED, ahs_pkg::RST_BACKOFF_PULSES};
	logic [3:0] phase_q = PHASE_STOP;
	logic signed [ahs_pkg::POS_W-1:0] home_pos_q = '0;

	ahs_pkg::out_item_t pending_cmds[$];
	ahs_pkg::out_item_t head_cmd;
	ahs_pkg::out_item_t next_cmd;
	poll_row_t directed_rows[$];

	int mismatches = 0;
	int sent = 0;
	int send_idle = 33;
	int recv_idle = 63;
	int idle_cycles = 0;

	axis_homing_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// model of the sequencer
	// ------------------------------------------------------------------
	function automatic logic [ahs_pkg::SPEED_W-1:0] speed_or_one(
			logic [ahs_pkg::SPEED_W-1:0] s);
		return (s == '0) ? ahs_pkg::SPEED_W'(1) : s;
	endfunction

	// logical jog directions mapped onto the raw card commands
	function automatic logic [2:0] jog_plus();
		return set_q.count_direction ? ahs_pkg::JOG_FWD : ahs_pkg::JOG_REV;
	endfunction

	function automatic logic [2:0] jog_minus();
		return set_q.count_direction ? ahs_pkg::JOG_REV : ahs_pkg::JOG_FWD;
	endfunction

	function automatic logic [2:0] jog_to_home();
		return set_q.home_toward_negative ? jog_minus() : jog_plus();
	endfunction

	// one poll in, one command word out; advances phase_q and home_pos_q
	function automatic ahs_pkg::out_item_t sequence_step(ahs_pkg::in_item_t req);
		ahs_pkg::out_item_t c;
		logic home_seen;
		logic lim_neg;
		logic lim_pos;
		logic [1:0] seek_mode;
		logic [1:0] leave_mode;
		logic signed [ahs_pkg::POS_W-1:0] p;
		c = '0;
		home_seen = set_q.sensor_active_high ? req.home_input : !req.home_input;
		seek_mode = set_q.sensor_active_high ? ahs_pkg::STOP_CODE12 : ahs_pkg::STOP_CODE8;
		leave_mode = set_q.sensor_active_high ? ahs_pkg::STOP_CODE8 : ahs_pkg::STOP_CODE12;
		if (!req.action) begin
			phase_q = PHASE_STOP;
		end else begin
			case (phase_q)
				PHASE_STOP: begin
					// stop goes out even while the card is busy
					c.issue_stop = 1'b1;
					if (!req.busy_req) begin
						c.speed_write = 1'b1;
						c.speed_value = speed_or_one(set_q.fast_speed);
						c.stop_mode_write = 1'b1;
						c.stop_mode = seek_mode;
						if (!home_seen)
							c.move_cmd = jog_to_home();
						phase_q = PHASE_SEARCH;
					end
				end
				PHASE_SEARCH: begin
					if (!req.busy_req) begin
						if (req.stopped_by_home || home_seen) begin
							phase_q = PHASE_LEAVE;
						end else begin
							// limit flags are on hardware sides
							lim_neg = set_q.count_direction ? req.stop_flag_b : req.stop_flag_a;
							lim_pos = set_q.count_direction ? req.stop_flag_a : req.stop_flag_b;
							if (lim_neg)
								c.move_cmd = jog_plus();
							else if (lim_pos)
								c.move_cmd = jog_minus();
							else
								c.move_cmd = jog_to_home();
						end
					end
				end
				PHASE_LEAVE: begin
					if (!req.busy_req) begin
						c.stop_mode_write = 1'b1;
						c.stop_mode = leave_mode;
						c.move_cmd = set_q.home_toward_negative ? jog_plus() : jog_minus();
						phase_q = PHASE_BACKOFF;
					end
				end
				PHASE_BACKOFF: begin
					if (!req.busy_req) begin
						c.speed_write = 1'b1;
						c.speed_value = speed_or_one(set_q.slow_speed);
						c.move_cmd = (set_q.count_direction == set_q.home_toward_negative) ?
							ahs_pkg::PULSE_FWD : ahs_pkg::PULSE_REV;
						c.move_pulses = set_q.backoff_pulses;
						phase_q = PHASE_APPROACH;
					end
				end
				PHASE_APPROACH: begin
					if (!req.busy_req) begin
						c.speed_write = 1'b1;
						c.speed_value = speed_or_one(set_q.slow_speed);
						c.stop_mode_write = 1'b1;
						c.stop_mode = seek_mode;
						c.move_cmd = jog_to_home();
						phase_q = PHASE_CHECK;
					end
				end
				PHASE_CHECK: begin
					if (!req.busy_req)
						phase_q = (req.stopped_by_home || home_seen) ? PHASE_LATCH : PHASE_STOP;
				end
				PHASE_LATCH: begin
					// busy is ignored here; mirrored count saturates on the most negative
					p = req.position_raw;
					if (!set_q.count_direction)
						p = (p == ahs_pkg::POS_MIN) ? ahs_pkg::POS_MAX : -p;
					home_pos_q = p;
					c.stop_mode_write = 1'b1;
					c.stop_mode = ahs_pkg::STOP_NONE;
					c.speed_write = 1'b1;
					c.speed_value = speed_or_one(set_q.work_speed);
					phase_q = PHASE_DONE;
				end
				default: ;
			endcase
		end
		c.phase = phase_q;
		c.done_res = (phase_q == PHASE_DONE);
		c.home_position = home_pos_q;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// row builders for the directed table
	// ------------------------------------------------------------------
	function automatic ahs_pkg::in_item_t status_poll(logic act, logic busy, logic hin,
			logic byh, logic fa, logic fb, logic signed [ahs_pkg::POS_W-1:0] pos);
		ahs_pkg::in_item_t r;
		r.action = act;
		r.busy_req = busy;
		r.home_input = hin;
		r.stopped_by_home = byh;
		r.stop_flag_a = fa;
		r.stop_flag_b = fb;
		r.position_raw = pos;
		return r;
	endfunction

	function automatic ahs_pkg::out_item_t command_word(logic stop, logic spw,
			logic [ahs_pkg::SPEED_W-1:0] spv, logic smw, logic [1:0] sm, logic [2:0] mv,
			logic [ahs_pkg::PULSE_W-1:0] mp, logic [3:0] ph,
			logic signed [ahs_pkg::POS_W-1:0] hp);
		ahs_pkg::out_item_t c;
		c.issue_stop = stop;
		c.speed_write = spw;
		c.speed_value = spv;
		c.stop_mode_write = smw;
		c.stop_mode = sm;
		c.move_cmd = mv;
		c.move_pulses = mp;
		c.phase = ph;
		c.done_res = (ph == PHASE_DONE);
		c.home_position = hp;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			if (mismatches < 60)
				$display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
			mismatches++;
		end
	endtask

	// Command words are compared before the request of the same edge is
	// modeled; a word always belongs to a request accepted earlier.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_cmds.size() == 0) begin
					report_mismatch("command word with no request pending", 32'd1, 32'd0);
				end else begin
					head_cmd = pending_cmds.pop_front();
					report_mismatch("issue_stop", 32'(out_data.issue_stop),
						32'(head_cmd.issue_stop));
					report_mismatch("speed_write", 32'(out_data.speed_write),
						32'(head_cmd.speed_write));
					report_mismatch("speed_value", 32'(out_data.speed_value),
						32'(head_cmd.speed_value));
					report_mismatch("stop_mode_write", 32'(out_data.stop_mode_write),
						32'(head_cmd.stop_mode_write));
					report_mismatch("stop_mode", 32'(out_data.stop_mode),
						32'(head_cmd.stop_mode));
					report_mismatch("move_cmd", 32'(out_data.move_cmd),
						32'(head_cmd.move_cmd));
					report_mismatch("move_pulses", 32'(out_data.move_pulses),
						32'(head_cmd.move_pulses));
					report_mismatch("phase", 32'(out_data.phase), 32'(head_cmd.phase));
					report_mismatch("done_res", 32'(out_data.done_res),
						32'(head_cmd.done_res));
					report_mismatch("home_position", 32'(out_data.home_position),
						32'(head_cmd.home_position));
				end
			end
			if (in_valid && in_ready) begin
				// model always runs so its state tracks; a typed row overrides the word
				next_cmd = sequence_step(in_data);
				if (typed_q)
					next_cmd = typed_cmd;
				pending_cmds.push_back(next_cmd);
			end
		end
	end

	// receiver stalls at the rate of the current idling mode
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// the watchdog counts any handshake, register write or reset as progress
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("axis_homing_sequencer test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------
	// Idling modes by request count: sender-light/receiver-heavy, then the
	// reverse, then full rate on both sides.
	task automatic send_poll(ahs_pkg::in_item_t req, bit typed, ahs_pkg::out_item_t cmd);
		send_idle = (sent < 600) ? 33 : (sent < 1200) ? 63 : 0;
		recv_idle = (sent < 600) ? 63 : (sent < 1200) ? 33 : 0;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		typed_q <= typed;
		typed_cmd <= cmd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// hold off the sender until every pending command word has come back
	task automatic drain_commands();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_cmds.size() != 0);
	endtask

	task automatic reg_write(logic [ahs_pkg::IDX_W-1:0] idx, logic [ahs_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			ahs_pkg::REG_COUNT_DIRECTION:      set_q.count_direction = data[0];
			ahs_pkg::REG_HOME_TOWARD_NEGATIVE: set_q.home_toward_negative = data[0];
			ahs_pkg::REG_SENSOR_ACTIVE_HIGH:   set_q.sensor_active_high = data[0];
			ahs_pkg::REG_FAST_SPEED:     set_q.fast_speed = data[ahs_pkg::SPEED_W-1:0];
			ahs_pkg::REG_SLOW_SPEED:     set_q.slow_speed = data[ahs_pkg::SPEED_W-1:0];
			ahs_pkg::REG_WORK_SPEED:     set_q.work_speed = data[ahs_pkg::SPEED_W-1:0];
			ahs_pkg::REG_BACKOFF_PULSES: set_q.backoff_pulses = data[ahs_pkg::PULSE_W-1:0];
			default: ;
		endcase
	endtask

	initial begin
		int k;
		int n;
		logic [2:0] dir_bits;
		logic [ahs_pkg::CFG_W-1:0] d;
		ahs_pkg::in_item_t req;

		// Directed walk under reset settings: mirrored counting, home on the
		// positive side, active-high sensor. Typed rows cover reset state,
		// restart, the first fast jog, the saturated latch and the done hold.
		directed_rows.push_back('{status_poll(1, 1, 0, 0, 0, 0, 0), 1'b1,
			command_word(1, 0, 0, 0, ahs_pkg::STOP_NONE, ahs_pkg::MOVE_NONE, 0,
			PHASE_STOP, 0)});
		directed_rows.push_back('{status_poll(0, 1, 1, 1, 1, 1, ahs_pkg::POS_MAX), 1'b1,
			command_word(0, 0, 0, 0, ahs_pkg::STOP_NONE, ahs_pkg::MOVE_NONE, 0,
			PHASE_STOP, 0)});
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 0, 0, -1), 1'b1,
			command_word(1, 1, ahs_pkg::RST_FAST_SPEED, 1, ahs_pkg::STOP_CODE12,
			ahs_pkg::JOG_REV, 0, PHASE_SEARCH, 0)});
		directed_rows.push_back('{status_poll(1, 1, 0, 0, 1, 1, 0), 1'b0, '0});  // busy search
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 1, 0, 7), 1'b0, '0});  // forward limit
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 0, 1, 8), 1'b0, '0});  // reverse limit
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 1, 1, 9), 1'b0, '0});  // both limits
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 0, 1, 0, 0, 0), 1'b0, '0});  // stop by home
		directed_rows.push_back('{status_poll(1, 1, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 0, 0, 0, 0, 0), 1'b0, '0});  // home missed
		directed_rows.push_back('{status_poll(1, 0, 1, 0, 0, 0, 0), 1'b0, '0});  // already home
		directed_rows.push_back('{status_poll(1, 0, 1, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 1, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 1, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 1, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{status_poll(1, 0, 1, 0, 0, 0, 0), 1'b0, '0});  // home found
		directed_rows.push_back('{status_poll(1, 1, 0, 0, 1, 1, ahs_pkg::POS_MIN), 1'b1,
			command_word(0, 1, ahs_pkg::RST_WORK_SPEED, 1, ahs_pkg::STOP_NONE,
			ahs_pkg::MOVE_NONE, 0, PHASE_DONE, ahs_pkg::POS_MAX)});
		directed_rows.push_back('{status_poll(1, 0, 1, 1, 0, 0, 123), 1'b1,
			command_word(0, 0, 0, 0, ahs_pkg::STOP_NONE, ahs_pkg::MOVE_NONE, 0,
			PHASE_DONE, ahs_pkg::POS_MAX)});
		directed_rows.push_back('{status_poll(0, 0, 0, 0, 0, 0, 0), 1'b1,
			command_word(0, 0, 0, 0, ahs_pkg::STOP_NONE, ahs_pkg::MOVE_NONE, 0,
			PHASE_STOP, ahs_pkg::POS_MAX)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_poll(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].cmd);

		// Random part: block 0 keeps reset settings, block 1 all minimum
		// (zero speeds go out as one), block 2 all maximum, the rest mixed.
		for (k = 0; k < RAND_BLOCKS; k++) begin
			if (k != 0) begin
				drain_commands();
				dir_bits = (k == 1) ? 3'b000 : (k == 2) ? 3'b111 : 3'(k - 2);
				d = ahs_pkg::CFG_W'($urandom);
				d[0] = dir_bits[0];
				reg_write(ahs_pkg::REG_COUNT_DIRECTION, d);
				d = ahs_pkg::CFG_W'($urandom);
				d[0] = dir_bits[1];
				reg_write(ahs_pkg::REG_HOME_TOWARD_NEGATIVE, d);
				d = ahs_pkg::CFG_W'($urandom);
				d[0] = dir_bits[2];
				reg_write(ahs_pkg::REG_SENSOR_ACTIVE_HIGH, d);
				d = (k == 1) ? '0 : (k == 2) ? '1 : ahs_pkg::CFG_W'($urandom);
				reg_write(ahs_pkg::REG_FAST_SPEED, d);
				d = (k == 1) ? '0 : (k == 2) ? '1 : ahs_pkg::CFG_W'($urandom);
				reg_write(ahs_pkg::REG_SLOW_SPEED, d);
				d = (k == 1) ? '0 : (k == 2) ? '1 : ahs_pkg::CFG_W'($urandom);
				reg_write(ahs_pkg::REG_WORK_SPEED, d);
				d = (k == 1) ? '0 : (k == 2) ? '1 : ahs_pkg::CFG_W'($urandom);
				reg_write(ahs_pkg::REG_BACKOFF_PULSES, d);
				reg_write(REG_UNUSED, ahs_pkg::CFG_W'($urandom));
				cfg_we <= 1'b0;
			end
			for (n = 0; n < POLLS_PER_SET; n++) begin
				if ($urandom_range(79) == 0)
					drain_commands();
				// mostly polls with a free card so the phases advance; a
				// restart now and then reopens the sequence after done
				req = status_poll($urandom_range(19) != 0, $urandom_range(3) == 0,
					1'($urandom_range(1)), $urandom_range(2) == 0, $urandom_range(4) == 0,
					$urandom_range(4) == 0, ahs_pkg::POS_W'($urandom));
				case ($urandom_range(7))
					0: req.position_raw = ahs_pkg::POS_MIN;
					1: req.position_raw = ahs_pkg::POS_MAX;
					2: req.position_raw = '0;
					3: req.position_raw = '1;
					default: ;
				endcase
				send_poll(req, 1'b0, '0);
			end
		end

		drain_commands();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("axis_homing_sequencer test passed");
		else
			$display("axis_homing_sequencer test failed");
		$finish;
	end

endmodule
